@@ hw/rtl/mie_pkg.sv @@
`timescale 1ns / 1ps

package mie_pkg;

  localparam int unsigned MemWordsDef = 1024;
  localparam int unsigned XLen        = 32;
  localparam int unsigned RegIdxW     = 5;
  localparam int unsigned OutW        = 144;

  typedef enum logic [5:0] {
    OP_BEQ   = 6'h04,
    OP_BNE   = 6'h05,
    OP_ADDI  = 6'h08,
    OP_ADDIU = 6'h09,
    OP_SLTI  = 6'h0A,
    OP_ANDI  = 6'h0C,
    OP_ORI   = 6'h0D,
    OP_NORI  = 6'h0E,
    OP_LUI   = 6'h0F,
    OP_LB    = 6'h20,
    OP_LH    = 6'h21,
    OP_LW    = 6'h23,
    OP_LBU   = 6'h24,
    OP_LHU   = 6'h25,
    OP_SB    = 6'h28,
    OP_SH    = 6'h29,
    OP_SW    = 6'h2B
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_OPCODE   = 2'd1,
    FAULT_MISALIGN = 2'd2
  } fault_e;

  // register file write port
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [XLen-1:0]    data;
  } rf_wr_t;

endpackage

@@ hw/rtl/mie_regfile.sv @@
`timescale 1ns / 1ps

// 32 x 32 register file: two registered read ports, one write port.
// Entries never written read as zero; a write on the read edge is forwarded.
module mie_regfile (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [mie_pkg::RegIdxW-1:0]       rs_idx_i,
  input  logic [mie_pkg::RegIdxW-1:0]       rt_idx_i,
  input  mie_pkg::rf_wr_t                   wr_i,
  output logic [mie_pkg::XLen-1:0]          rs_data_o,
  output logic [mie_pkg::XLen-1:0]          rt_data_o
);

  localparam int unsigned Depth = 2 ** mie_pkg::RegIdxW;

  logic [mie_pkg::XLen-1:0] mem [Depth];
  logic [Depth-1:0]         vld_q;

  logic [mie_pkg::XLen-1:0] ram_rs_q, ram_rt_q, fwd_q;
  logic                     vld_rs_q, vld_rt_q, hit_rs_q, hit_rt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ram_rs_q <= mem[rs_idx_i];
      ram_rt_q <= mem[rt_idx_i];
      vld_rs_q <= vld_q[rs_idx_i];
      vld_rt_q <= vld_q[rt_idx_i];
      hit_rs_q <= wr_i.en && (wr_i.idx == rs_idx_i);
      hit_rt_q <= wr_i.en && (wr_i.idx == rt_idx_i);
      fwd_q    <= wr_i.data;
    end
  end

  assign rs_data_o = hit_rs_q ? fwd_q : (vld_rs_q ? ram_rs_q : '0);
  assign rt_data_o = hit_rt_q ? fwd_q : (vld_rt_q ? ram_rt_q : '0);

endmodule

@@ hw/rtl/mie_dmem.sv @@
`timescale 1ns / 1ps

// Data memory, one registered read port and one write port.
// After reset, sweep every word to zero; busy_o is high during the sweep.
module mie_dmem #(
  parameter int unsigned MEM_WORDS = mie_pkg::MemWordsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MEM_WORDS)-1:0] rd_idx_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MEM_WORDS)-1:0] wr_idx_i,
  input  logic [mie_pkg::XLen-1:0]     wr_data_i,
  output logic [mie_pkg::XLen-1:0]     rd_data_o,
  output logic                         busy_o
);

  localparam int unsigned IdxW = $clog2(MEM_WORDS);

  logic [mie_pkg::XLen-1:0] mem [MEM_WORDS];
  logic [IdxW-1:0]          clr_idx_q, clr_idx_d;
  logic                     busy_q, busy_d;
  logic                     we;
  logic [IdxW-1:0]          widx;
  logic [mie_pkg::XLen-1:0] wdata;

  always_comb begin
    clr_idx_d = clr_idx_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == IdxW'(MEM_WORDS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_idx_q <= clr_idx_d;
      busy_q    <= busy_d;
    end
  end

  assign we    = busy_q | wr_en_i;
  assign widx  = busy_q ? clr_idx_q : wr_idx_i;
  assign wdata = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[widx] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_idx_i];
    end
  end

  assign busy_o = busy_q;

endmodule

@@ hw/rtl/mips_itype_execute.sv @@
`timescale 1ns / 1ps
// An accepted word passes E1 and E2; its result is registered on m_axis as it leaves E2.
// No new word is taken until the last one leaves E2 and writes back to the register file.
// Reset: PC clears at once, the register file reads zero through per-entry valid bits,
// and data memory is swept to zero with s_axis_tready held low.
// MEM_WORDS must be a power of two; the word index is address bits above the byte lane.
module mips_itype_execute #(
  parameter int unsigned MEM_WORDS = mie_pkg::MemWordsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // slave side
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // [31:0] instruction
  // master side
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] reg_write, [5:1] reg_index, [37:6] reg_value, [38] branch_taken,
  // [70:39] pc_value, [71] mem_write, [103:72] mem_address, [135:104] mem_word,
  // [137:136] fault, [143:138] zero
  output logic [mie_pkg::OutW-1:0]  m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(MEM_WORDS);

  // -------------------------------------------------------------------------
  // Handshake and stage control
  // E1: register operands arrive, address and ALU result are formed, data
  //     memory read is issued.
  // E2: memory word arrives, loads/stores are finished, writeback happens
  //     when the word moves into the output register.
  // -------------------------------------------------------------------------
  logic s_fire, e2_adv, dm_busy;
  logic e1_valid_q, e2_valid_q, out_valid_q;

  assign e2_adv        = e2_valid_q && (!out_valid_q || m_axis_tready);
  // Take a new word only if dmem is idle, E1 is empty and E2 is empty or frees up this edge.
  assign s_axis_tready = !dm_busy && !e1_valid_q && (!e2_valid_q || e2_adv);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q  <= 1'b0;
      e2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      e1_valid_q <= s_fire;
      if (e1_valid_q) begin
        e2_valid_q <= 1'b1;
      end else if (e2_adv) begin
        e2_valid_q <= 1'b0;
      end
      if (e2_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Register file
  // -------------------------------------------------------------------------
  mie_pkg::rf_wr_t          rf_wr;
  logic [mie_pkg::XLen-1:0] rs_data, rt_data;

  mie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_fire),
    .rs_idx_i  (s_axis_tdata[25:21]),
    .rt_idx_i  (s_axis_tdata[20:16]),
    .wr_i      (rf_wr),
    .rs_data_o (rs_data),
    .rt_data_o (rt_data)
  );

  // -------------------------------------------------------------------------
  // E1: decode and ALU
  // -------------------------------------------------------------------------
  logic [31:0]            ins_q;
  mie_pkg::op_e           op1;
  logic [15:0]            imm1;
  logic [31:0]            simm1, addr1, val1;
  logic                   taken1;
  mie_pkg::fault_e        fault1;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ins_q <= s_axis_tdata;
    end
  end

  assign op1   = mie_pkg::op_e'(ins_q[31:26]);
  assign imm1  = ins_q[15:0];
  assign simm1 = {{16{imm1[15]}}, imm1};
  assign addr1 = rs_data + simm1;

  always_comb begin
    val1   = '0;
    taken1 = 1'b0;
    case (op1)
      mie_pkg::OP_BEQ:   taken1 = (rs_data == rt_data);
      mie_pkg::OP_BNE:   taken1 = (rs_data != rt_data);
      mie_pkg::OP_ADDI,
      mie_pkg::OP_ADDIU: val1 = addr1;
      mie_pkg::OP_SLTI:  val1 = {31'b0, $signed(rs_data) < $signed(simm1)};
      mie_pkg::OP_ANDI:  val1 = rs_data & {16'b0, imm1};
      mie_pkg::OP_ORI:   val1 = rs_data | {16'b0, imm1};
      mie_pkg::OP_NORI:  val1 = ~(rs_data | {16'b0, imm1});
      mie_pkg::OP_LUI:   val1 = {imm1, 16'b0};
      default:           val1 = '0;
    endcase
  end

  always_comb begin
    fault1 = mie_pkg::FAULT_NONE;
    if (!(op1 inside {mie_pkg::OP_BEQ, mie_pkg::OP_BNE, mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU,
                      mie_pkg::OP_SLTI, mie_pkg::OP_ANDI, mie_pkg::OP_ORI, mie_pkg::OP_NORI,
                      mie_pkg::OP_LUI, mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LW,
                      mie_pkg::OP_LBU, mie_pkg::OP_LHU, mie_pkg::OP_SB, mie_pkg::OP_SH,
                      mie_pkg::OP_SW})) begin
      fault1 = mie_pkg::FAULT_OPCODE;
    end else if ((op1 inside {mie_pkg::OP_LH, mie_pkg::OP_LHU, mie_pkg::OP_SH}) && addr1[0]) begin
      fault1 = mie_pkg::FAULT_MISALIGN;
    end
  end

  // E1 -> E2 payload
  mie_pkg::op_e    op2_q;
  logic [4:0]      rt2_q;
  logic [31:0]     simm2_q, b2_q, addr2_q, val2_q;
  logic            taken2_q;
  mie_pkg::fault_e fault2_q;

  always_ff @(posedge clk_i) begin
    if (e1_valid_q) begin
      op2_q    <= op1;
      rt2_q    <= ins_q[20:16];
      simm2_q  <= simm1;
      b2_q     <= rt_data;
      addr2_q  <= addr1;
      val2_q   <= val1;
      taken2_q <= taken1;
      fault2_q <= fault1;
    end
  end

  // -------------------------------------------------------------------------
  // Data memory: read issued on the E1 -> E2 edge, written on writeback
  // -------------------------------------------------------------------------
  logic [31:0] dm_rdata;
  logic        dm_we;
  logic [31:0] mword;

  mie_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (e1_valid_q),
    .rd_idx_i  (addr1[IdxW+1:2]),
    .wr_en_i   (dm_we),
    .wr_idx_i  (addr2_q[IdxW+1:2]),
    .wr_data_i (mword),
    .rd_data_o (dm_rdata),
    .busy_o    (dm_busy)
  );

  // -------------------------------------------------------------------------
  // E2: lane select, store merge, result assembly
  // -------------------------------------------------------------------------
  logic [1:0]  lane;
  logic [7:0]  byte_sel;
  logic [15:0] half_sel;
  logic [31:0] sb_word, sh_word;
  logic        wr_reg, mem_wr, is_mem, rw;
  logic [31:0] val;
  logic [31:0] pc_q, pc_d;
  logic        ok2;

  assign lane = addr2_q[1:0];
  assign ok2  = (fault2_q == mie_pkg::FAULT_NONE);

  // big-endian lanes: lane 0 is the top byte
  always_comb begin
    case (lane)
      2'd0: begin
        byte_sel = dm_rdata[31:24];
        sb_word  = {b2_q[7:0], dm_rdata[23:0]};
      end
      2'd1: begin
        byte_sel = dm_rdata[23:16];
        sb_word  = {dm_rdata[31:24], b2_q[7:0], dm_rdata[15:0]};
      end
      2'd2: begin
        byte_sel = dm_rdata[15:8];
        sb_word  = {dm_rdata[31:16], b2_q[7:0], dm_rdata[7:0]};
      end
      default: begin
        byte_sel = dm_rdata[7:0];
        sb_word  = {dm_rdata[31:8], b2_q[7:0]};
      end
    endcase
  end

  assign half_sel = lane[1] ? dm_rdata[15:0] : dm_rdata[31:16];
  assign sh_word  = lane[1] ? {dm_rdata[31:16], b2_q[15:0]} : {b2_q[15:0], dm_rdata[15:0]};

  always_comb begin
    wr_reg = 1'b0;
    mem_wr = 1'b0;
    is_mem = 1'b0;
    val    = val2_q;
    mword  = '0;
    case (op2_q)
      mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU, mie_pkg::OP_SLTI, mie_pkg::OP_ANDI,
      mie_pkg::OP_ORI, mie_pkg::OP_NORI, mie_pkg::OP_LUI: begin
        wr_reg = 1'b1;
      end
      mie_pkg::OP_LB: begin
        is_mem = 1'b1;
        wr_reg = 1'b1;
        mword  = dm_rdata;
        val    = {{24{byte_sel[7]}}, byte_sel};
      end
      mie_pkg::OP_LBU: begin
        is_mem = 1'b1;
        wr_reg = 1'b1;
        mword  = dm_rdata;
        val    = {24'b0, byte_sel};
      end
      mie_pkg::OP_LW: begin
        is_mem = 1'b1;
        wr_reg = 1'b1;
        mword  = dm_rdata;
        val    = dm_rdata;
      end
      mie_pkg::OP_LH, mie_pkg::OP_LHU: begin
        is_mem = 1'b1;
        if (ok2) begin
          wr_reg = 1'b1;
          mword  = dm_rdata;
          val    = (op2_q == mie_pkg::OP_LH) ? {{16{half_sel[15]}}, half_sel}
                                             : {16'b0, half_sel};
        end
      end
      mie_pkg::OP_SB: begin
        is_mem = 1'b1;
        mem_wr = 1'b1;
        mword  = sb_word;
      end
      mie_pkg::OP_SH: begin
        is_mem = 1'b1;
        if (ok2) begin
          mem_wr = 1'b1;
          mword  = sh_word;
        end
      end
      mie_pkg::OP_SW: begin
        is_mem = 1'b1;
        mem_wr = 1'b1;
        mword  = b2_q;
      end
      default: begin
        wr_reg = 1'b0;
      end
    endcase
  end

  assign rw    = wr_reg && (rt2_q != '0);
  assign pc_d  = taken2_q ? pc_q + simm2_q : pc_q;
  assign dm_we = e2_adv && mem_wr;

  assign rf_wr.en   = e2_adv && rw;
  assign rf_wr.idx  = rt2_q;
  assign rf_wr.data = val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (e2_adv) begin
      pc_q <= pc_d;
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic [mie_pkg::OutW-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (e2_adv) begin
      out_data_q <= {6'b0, fault2_q, mword, (is_mem ? addr2_q : 32'b0), mem_wr,
                     pc_d, taken2_q, val, rt2_q, rw};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // E1 is only filled when E2 is empty or drains on the same edge
  a_e1_e2_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e1_valid_q |-> !e2_valid_q)
    else $error("E1 and E2 occupied together");

  // no word enters while memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dm_busy |-> !s_axis_tready)
    else $error("accept during memory clear");

  // register zero is never written
  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> (rf_wr.idx != '0))
    else $error("write to register zero");

  // a faulting word changes no state
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e2_adv && !ok2) |-> (!rf_wr.en && !dm_we && (pc_d == pc_q)))
    else $error("faulting word changed state");

endmodule

@@ test/mips_itype_execute_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for mips_itype_execute: drive I-type instruction words on s_axis,
// retire each one in a behavioral copy of the register file, PC and data memory, and
// compare every m_axis word field by field with the oldest predicted retire record.
module mips_itype_execute_test;
  import mie_pkg::*;

  localparam int unsigned MemWords   = MemWordsDef;
  localparam int unsigned MemIdxW    = $clog2(MemWords);
  localparam int unsigned CycleLimit = 200000;  // covers the memory sweep with wide margin
  localparam int unsigned HoldOff    = 300;     // long receiver stall, in cycles
  // opcodes outside the executed set
  localparam logic [5:0]  OpSpecial  = 6'h00;
  localparam logic [5:0]  OpUnused   = 6'h3F;

  // Same bit order as m_axis_tdata: reg_write sits in bit 0, fault on top.
  typedef struct packed {
    fault_e      fault;
    logic [31:0] mem_word;
    logic [31:0] mem_address;
    logic        mem_write;
    logic [31:0] pc_value;
    logic        branch_taken;
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_write;
  } retire_t;

  localparam int unsigned RetireW = $bits(retire_t);

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [31:0]     s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  // behavioral architectural state
  logic [31:0] gpr_model [32];
  logic [31:0] pc_model;
  logic [31:0] dmem_model [MemWords];

  retire_t     retire_q [$];
  int unsigned words_sent;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_request;

  op_e op_table [17] = '{OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI,
                         OP_NORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB,
                         OP_SH, OP_SW};
  op_e alu_ops   [7]  = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI};
  op_e load_ops  [5]  = '{OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW};
  op_e store_ops [3]  = '{OP_SB, OP_SH, OP_SW};

  mips_itype_execute u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Instruction helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] encode_itype(logic [5:0] code, logic [4:0] rs,
                                               logic [4:0] rt, logic [15:0] imm);
    return {code, rs, rt, imm};
  endfunction

  function automatic bit is_known_op(logic [5:0] code);
    case (code)
      OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI,
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
  endfunction

  // Mix full-range immediates with small, negative and boundary values.
  function automatic logic [15:0] pick_imm();
    case ($urandom_range(4))
      1:       return 16'($urandom_range(31));
      2:       return 16'($urandom_range(3)) == 0 ? 16'h7FFF :
                      ($urandom_range(1) == 0 ? 16'h8000 : 16'hFFFF);
      3:       return 16'h0000 - 16'($urandom_range(1, 32));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offset around a base: hits all byte lanes and odd halfword addresses.
  function automatic logic [15:0] near_offset();
    return 16'($urandom_range(23)) - 16'd8;
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [5:0] code;
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        do code = 6'($urandom_range(63)); while (is_known_op(code));
        return {code, 26'($urandom)};
      end
      default: return encode_itype(op_table[$urandom_range(16)], pick_reg(), pick_reg(),
                                   pick_imm());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: retire one instruction against the behavioral state
  // ---------------------------------------------------------------------------
  task automatic clear_model();
    foreach (gpr_model[i]) gpr_model[i] = '0;
    foreach (dmem_model[i]) dmem_model[i] = '0;
    pc_model = '0;
  endtask

  task automatic retire_instruction(input logic [31:0] ins);
    retire_t            rec;
    logic [5:0]         op;
    logic [4:0]         rs, rt;
    logic [15:0]        imm;
    logic [31:0]        simm, a, b, addr, word, shifted, val, mword;
    logic [MemIdxW-1:0] widx;
    logic [1:0]         lane;
    int                 bsh, hsh;
    logic               taken, wr_reg, wr_mem, is_mem;
    fault_e             fault;
    op     = ins[31:26];
    rs     = ins[25:21];
    rt     = ins[20:16];
    imm    = ins[15:0];
    simm   = {{16{imm[15]}}, imm};
    a      = gpr_model[rs];
    b      = gpr_model[rt];
    addr   = a + simm;
    lane   = addr[1:0];
    widx   = addr[MemIdxW+1:2];  // word index wraps at the memory size
    word   = dmem_model[widx];
    bsh    = 24 - 8 * int'(lane);  // big-endian byte lane
    hsh    = 16 - 8 * int'(lane);  // halfword lane, even lanes only
    taken  = 1'b0;
    wr_reg = 1'b0;
    wr_mem = 1'b0;
    is_mem = 1'b0;
    val    = '0;
    mword  = '0;
    fault  = FAULT_NONE;
    case (op)
      OP_BEQ: taken = (a == b);
      OP_BNE: taken = (a != b);
      OP_ADDI, OP_ADDIU: begin
        val = a + simm;  // no overflow trap
        wr_reg = 1'b1;
      end
      OP_SLTI: begin
        val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        wr_reg = 1'b1;
      end
      OP_ANDI: begin
        val = a & {16'h0000, imm};
        wr_reg = 1'b1;
      end
      OP_ORI: begin
        val = a | {16'h0000, imm};
        wr_reg = 1'b1;
      end
      OP_NORI: begin
        val = ~(a | {16'h0000, imm});
        wr_reg = 1'b1;
      end
      OP_LUI: begin
        val = {imm, 16'h0000};
        wr_reg = 1'b1;
      end
      OP_LB, OP_LBU: begin
        is_mem  = 1'b1;
        mword   = word;
        shifted = word >> bsh;
        val     = (op == OP_LB) ? {{24{shifted[7]}}, shifted[7:0]} : {24'h0, shifted[7:0]};
        wr_reg  = 1'b1;
      end
      OP_LW: begin
        is_mem = 1'b1;  // low address bits ignored
        mword  = word;
        val    = word;
        wr_reg = 1'b1;
      end
      OP_LH, OP_LHU: begin
        is_mem = 1'b1;
        if (lane[0]) begin
          fault = FAULT_MISALIGN;  // odd halfword: no state change
        end else begin
          mword   = word;
          shifted = word >> hsh;
          val     = (op == OP_LH) ? {{16{shifted[15]}}, shifted[15:0]} :
                                    {16'h0000, shifted[15:0]};
          wr_reg  = 1'b1;
        end
      end
      OP_SB: begin
        is_mem = 1'b1;
        mword  = (word & ~(32'h0000_00FF << bsh)) | ((b & 32'h0000_00FF) << bsh);
        wr_mem = 1'b1;
      end
      OP_SH: begin
        is_mem = 1'b1;
        if (lane[0]) begin
          fault = FAULT_MISALIGN;
        end else begin
          mword  = (word & ~(32'h0000_FFFF << hsh)) | ((b & 32'h0000_FFFF) << hsh);
          wr_mem = 1'b1;
        end
      end
      OP_SW: begin
        is_mem = 1'b1;
        mword  = b;
        wr_mem = 1'b1;
      end
      default: fault = FAULT_OPCODE;
    endcase

    if (taken) pc_model = pc_model + simm;  // unshifted offset
    if (wr_mem) dmem_model[widx] = mword;
    if (wr_reg && rt != 5'd0) gpr_model[rt] = val;

    rec.reg_write    = wr_reg && rt != 5'd0;
    rec.reg_index    = rt;
    rec.reg_value    = val;
    rec.branch_taken = taken;
    rec.pc_value     = pc_model;
    rec.mem_write    = wr_mem;
    rec.mem_address  = is_mem ? addr : 32'd0;
    rec.mem_word     = mword;
    rec.fault        = fault;
    retire_q.push_back(rec);
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one word and hold it until accepted. tvalid stays high on return so a
  // back-to-back word follows with no bubble; a pause or a next call that idles drops it.
  task automatic send_word(input logic [31:0] ins);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ins;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    retire_instruction(ins);
    words_sent++;
  endtask

  // Drop tvalid and wait for every predicted word to come back.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (retire_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_register(input logic [4:0] r, input logic [31:0] value);
    send_word(encode_itype(OP_LUI, 5'd0, r, value[31:16]));
    send_word(encode_itype(OP_ORI, r, r, value[15:0]));
  endtask

  // ---------------------------------------------------------------------------
  // Well-formed sequences with random content
  // ---------------------------------------------------------------------------
  // Point a base register into memory, store a few lanes, then load near the same base.
  task automatic run_memory_sequence();
    logic [4:0]  base_reg, data_reg, dest_reg;
    logic [31:0] base;
    int unsigned n;
    base_reg = 5'($urandom_range(1, 31));
    do data_reg = 5'($urandom_range(1, 31)); while (data_reg == base_reg);
    // mostly inside the memory, sometimes far out so the index wraps
    base = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(MemWords * 4 - 1));
    load_register(base_reg, base);
    load_register(data_reg, $urandom);
    n = $urandom_range(1, 4);
    repeat (n) begin
      send_word(encode_itype(store_ops[$urandom_range(2)], base_reg, data_reg,
                             near_offset()));
    end
    repeat (n + 1) begin
      do dest_reg = 5'($urandom_range(31)); while (dest_reg == base_reg);
      send_word(encode_itype(load_ops[$urandom_range(4)], base_reg, dest_reg,
                             near_offset()));
    end
  endtask

  task automatic run_alu_chain();
    logic [4:0] src_reg, dst_reg;
    src_reg = 5'($urandom_range(1, 31));
    load_register(src_reg, $urandom);
    repeat ($urandom_range(2, 3)) begin
      dst_reg = pick_reg();
      send_word(encode_itype(alu_ops[$urandom_range(6)], src_reg, dst_reg, pick_imm()));
      if (dst_reg != 5'd0) src_reg = dst_reg;  // chain on the fresh result
    end
  endtask

  task automatic run_branch_pair();
    logic [4:0] rs, rt;
    rs = pick_reg();
    rt = ($urandom_range(1) == 0) ? rs : pick_reg();
    send_word(encode_itype(($urandom_range(1) == 0) ? OP_BEQ : OP_BNE, rs, rt, pick_imm()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_alu_and_branch_edges();
    send_word(encode_itype(OP_LUI,   5'd0, 5'd1, 16'hFFFF));  // r1 = 0xFFFF0000
    send_word(encode_itype(OP_ORI,   5'd1, 5'd1, 16'hFFFF));  // r1 = all ones
    send_word(encode_itype(OP_ADDI,  5'd1, 5'd2, 16'h0001));  // wraps to zero, no trap
    send_word(encode_itype(OP_ADDIU, 5'd1, 5'd3, 16'h8000));  // sign-extended immediate
    send_word(encode_itype(OP_SLTI,  5'd1, 5'd4, 16'h0000));  // -1 < 0 holds
    send_word(encode_itype(OP_SLTI,  5'd0, 5'd4, 16'h8000));  // 0 < -32768 fails
    send_word(encode_itype(OP_ANDI,  5'd1, 5'd5, 16'h8001));  // zero-extended mask
    send_word(encode_itype(OP_NORI,  5'd0, 5'd6, 16'h0000));
    send_word(encode_itype(OP_ADDI,  5'd1, 5'd0, 16'h7FFF));  // r0 must stay zero
    send_word(encode_itype(OP_BEQ,   5'd0, 5'd0, 16'h7FFF));  // taken, largest step forward
    send_word(encode_itype(OP_BNE,   5'd1, 5'd2, 16'h8000));  // taken, largest step back
    send_word(encode_itype(OP_BEQ,   5'd1, 5'd0, 16'h1234));  // not taken
  endtask

  task automatic test_memory_lanes();
    send_word(encode_itype(OP_SW,  5'd0, 5'd1,  16'h0000));
    send_word(encode_itype(OP_SB,  5'd0, 5'd5,  16'h0001));  // merge byte lane 1
    send_word(encode_itype(OP_SH,  5'd0, 5'd3,  16'h0002));  // merge low halfword
    send_word(encode_itype(OP_SH,  5'd0, 5'd3,  16'h0001));  // odd address: fault
    send_word(encode_itype(OP_LB,  5'd0, 5'd7,  16'h0000));  // negative byte
    send_word(encode_itype(OP_LBU, 5'd0, 5'd8,  16'h0003));
    send_word(encode_itype(OP_LH,  5'd0, 5'd9,  16'h0002));
    send_word(encode_itype(OP_LHU, 5'd0, 5'd10, 16'h0000));
    send_word(encode_itype(OP_LHU, 5'd0, 5'd10, 16'h0003));  // odd address: fault
    send_word(encode_itype(OP_LW,  5'd0, 5'd11, 16'h0003));  // low bits ignored
    send_word(encode_itype(OP_SW,  5'd0, 5'd1,  16'hFFFC));  // top of address space
    send_word(encode_itype(OP_LW,  5'd0, 5'd12, 16'h0FFC));  // aliases the same word
    send_word(encode_itype(OP_LB,  5'd0, 5'd0,  16'h0002));  // load into r0
  endtask

  task automatic test_bad_encodings();
    send_word({OpSpecial, 26'h3FF_FFFF});
    send_word({OpUnused, 26'h000_0000});
  endtask

  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2: run_memory_sequence();
        3:       run_branch_pair();
        4, 5:    run_alu_chain();
        default: send_word(random_instruction());
      endcase
    end
  endtask

  // Stall the receiver for a long stretch while words keep coming, so the
  // block fills and drops s_axis_tready; then let everything drain.
  task automatic test_output_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_request  = HoldOff;
    repeat (24) send_word(random_instruction());
    pause_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
    end
  endtask

  // Compare every accepted result word with the oldest prediction.
  initial begin : retire_checker
    retire_t want, got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = retire_t'(m_axis_tdata[RetireW-1:0]);
        if (retire_q.size() == 0) begin
          error_count++;
          $display("%0t unexpected result: expected none actual %h", $time, m_axis_tdata);
        end else begin
          want = retire_q.pop_front();
          check_field("reg_write",    32'(want.reg_write),    32'(got.reg_write));
          check_field("reg_index",    32'(want.reg_index),    32'(got.reg_index));
          check_field("reg_value",    want.reg_value,         got.reg_value);
          check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
          check_field("pc_value",     want.pc_value,          got.pc_value);
          check_field("mem_write",    32'(want.mem_write),    32'(got.mem_write));
          check_field("mem_address",  want.mem_address,       got.mem_address);
          check_field("mem_word",     want.mem_word,          got.mem_word);
          check_field("fault",        32'(want.fault),        32'(got.fault));
          check_field("pad",          32'd0,                  32'(m_axis_tdata[OutW-1:RetireW]));
        end
      end
    end
  end

  // Watchdog: fail the run if it hangs.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : sequencer
    words_sent    = 0;
    error_count   = 0;
    hold_request  = 0;
    src_idle_pct  = 7;
    sink_idle_pct = 60;
    clear_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;  // the block then sweeps memory with s_axis_tready low

    test_alu_and_branch_edges();
    test_memory_lanes();
    test_bad_encodings();
    test_random_traffic(230);

    src_idle_pct  = 60;
    sink_idle_pct = 7;
    test_random_traffic(230);

    test_output_backpressure();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(230);

    pause_until_drained();
    repeat (10) @(posedge clk_i);  // catch any stray extra result
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mie_pkg.sv
hw/rtl/mie_regfile.sv
hw/rtl/mie_dmem.sv
hw/rtl/mips_itype_execute.sv
test/mips_itype_execute_test.sv
